>>> src/ydr_pkg.sv
// ----------------------------------------------------------------------------
// ydr_pkg
// Shared types, constants and elaboration-time table builders for the
// yuv difference pixel renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package ydr_pkg;

    // frame width clamp default
    localparam int unsigned MAX_WIDTH_DEF = 4096;

    // configuration register indexes
    localparam logic CFG_TEN_BIT     = 1'b0;
    localparam logic CFG_FRAME_WIDTH = 1'b1;

    localparam logic [12:0] FRAME_WIDTH_RST = 13'd1920;

    // render modes
    localparam logic [2:0] MODE_A       = 3'd0;
    localparam logic [2:0] MODE_B       = 3'd1;
    localparam logic [2:0] MODE_HEAT    = 3'd2;
    localparam logic [2:0] MODE_MASK    = 3'd3;
    localparam logic [2:0] MODE_COMPARE = 3'd4;

    // what the last stage does with an item
    localparam logic [1:0] KIND_CSC     = 2'd0;
    localparam logic [1:0] KIND_MISSING = 2'd1;
    localparam logic [1:0] KIND_HEAT    = 2'd2;
    localparam logic [1:0] KIND_BLEND   = 2'd3;

    // bt.601 full range, q16
    localparam logic signed [17:0] COEF_RV = 18'sd91881;
    localparam logic signed [17:0] COEF_GU = 18'sd22554;
    localparam logic signed [17:0] COEF_GV = 18'sd46802;
    localparam logic signed [17:0] COEF_BU = 18'sd116130;

    // mask blend, q16
    localparam logic [23:0] BLEND_GAIN     = 24'd26214;
    localparam logic [23:0] BLEND_RED_BIAS = 24'd10059776;
    localparam logic [23:0] BLEND_BIAS     = 24'd32768;

    // heat table geometry
    localparam int unsigned HEAT_DEPTH    = 256;
    localparam int unsigned RGB_BITS      = 24;
    localparam int unsigned HEAT_TAB_BITS = HEAT_DEPTH * RGB_BITS;
    localparam int unsigned DEPTH_MAX_8   = 255;
    localparam int unsigned DEPTH_MAX_10  = 1023;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // stage advance strobes handed to the color converter
    typedef struct packed {
        logic s2;
        logic s3;
    } ydr_adv_t;

    // clamp and round one q16 accumulator to 8 bits
    function automatic logic [7:0] conv_channel(input logic signed [30:0] acc);
        logic [30:0] sum;
        sum = 31'($unsigned(acc)) + 31'd32768;
        if (acc < 0)
            return 8'd0;
        else if (acc > 31'sd16711680)
            return 8'd255;
        else
            return sum[23:16];
    endfunction

    // log2 in q24, n >= 1
    function automatic longint log2_q24(input longint n);
        longint p;
        longint y;
        longint frac;
        p    = 0;
        frac = 0;
        for (int i = 0; i < 31; i++) begin
            if ((n >> (i + 1)) != 0)
                p = i + 1;
        end
        y = n << (30 - p);
        for (int i = 0; i < 24; i++) begin
            y    = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (longint'(1) << 31)) begin
                frac = frac | 1;
                y    = y >> 1;
            end
        end
        return (p << 24) | frac;
    endfunction

    function automatic longint lin_channel(input longint t, input longint k);
        longint span;
        longint f;
        span = t - k;
        if (span < 0)
            span = -span;
        f = 98304 - 4 * span;
        if (f < 0)
            f = 0;
        if (f > 65536)
            f = 65536;
        return (f * 255 + 32768) >> 16;
    endfunction

    // one heatmap pixel for difference d at depth maximum m
    function automatic logic [23:0] heat_entry(input longint d, input longint m);
        longint lx;
        longint goal;
        longint t;
        longint lo;
        longint hi;
        longint mid;
        longint r;
        longint g;
        longint b;
        longint n;
        if (d == 0)
            return {8'd15, 8'd15, 8'd20};
        lx = log2_q24(6 * d) - log2_q24(m);
        if (lx >= 0) begin
            t = 65536;
        end else begin
            lo   = 0;
            hi   = 65535;
            goal = 13 * lx;
            for (int s = 0; s < 17; s++) begin
                if (lo < hi) begin
                    mid = (lo + hi + 1) >> 1;
                    if (20 * (log2_q24(mid) - (longint'(16) << 24)) <= goal)
                        lo = mid;
                    else
                        hi = mid - 1;
                end
            end
            t = lo;
        end
        r = lin_channel(t, 49152);
        g = lin_channel(t, 32768);
        b = lin_channel(t, 16384);
        if (t * 100 > 85 * 65536) begin
            n = (t * 100 - 5570560) * 255;
            g = (2 * n + 983040) / 1966080;
            if (g > 255)
                g = 255;
            r = 255;
            b = g;
        end
        return {r[7:0], g[7:0], b[7:0]};
    endfunction

    function automatic logic [HEAT_TAB_BITS-1:0] build_heat_tab(input longint m);
        logic [HEAT_TAB_BITS-1:0] tab;
        tab = '0;
        for (int i = 0; i < HEAT_DEPTH; i++)
            tab[i*RGB_BITS +: RGB_BITS] = heat_entry(longint'(i), m);
        return tab;
    endfunction

    localparam logic [HEAT_TAB_BITS-1:0] HEAT_TAB_8  = build_heat_tab(DEPTH_MAX_8);
    localparam logic [HEAT_TAB_BITS-1:0] HEAT_TAB_10 = build_heat_tab(DEPTH_MAX_10);
    // any difference of 256 or more saturates at either depth
    localparam logic [23:0] HEAT_SAT = heat_entry(HEAT_DEPTH, DEPTH_MAX_8);

endpackage

`default_nettype wire

>>> src/ydr_heat_rom.sv
// ----------------------------------------------------------------------------
// ydr_heat_rom
// Heatmap color table with registered read, one table per sample depth.
// ----------------------------------------------------------------------------
`default_nettype none

module ydr_heat_rom
    import ydr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       en,
    input  wire logic       ten_bit,
    input  wire logic [9:0] diff_value,
    output rgb_t            rgb
);

    rgb_t rgb_reg;
    rgb_t rgb_next;

    always_comb
    begin
        if (diff_value[9:8] != 2'b00)
            rgb_next = HEAT_SAT;
        else if (ten_bit)
            rgb_next = HEAT_TAB_10[diff_value[7:0]*RGB_BITS +: RGB_BITS];
        else
            rgb_next = HEAT_TAB_8[diff_value[7:0]*RGB_BITS +: RGB_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rgb_reg <= rgb_next;
    end

    assign rgb = rgb_reg;

endmodule

`default_nettype wire

>>> src/ydr_csc.sv
// ----------------------------------------------------------------------------
// ydr_csc
// Two-stage ycbcr to rgb converter: coefficient products, then sum and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module ydr_csc
    import ydr_pkg::*;
(
    input  wire logic               clk,
    input  wire ydr_adv_t           adv,
    input  wire logic [9:0]         y_in,
    input  wire logic signed [10:0] uc_in,
    input  wire logic signed [10:0] vc_in,
    output rgb_t                    rgb
);

    // product stage
    logic [9:0]         y_reg;
    logic signed [28:0] p_rv_reg;
    logic signed [28:0] p_gu_reg;
    logic signed [28:0] p_gv_reg;
    logic signed [28:0] p_bu_reg;
    logic signed [28:0] p_rv_next;
    logic signed [28:0] p_gu_next;
    logic signed [28:0] p_gv_next;
    logic signed [28:0] p_bu_next;

    // sum stage
    logic signed [30:0] yy;
    logic signed [30:0] acc_r;
    logic signed [30:0] acc_g;
    logic signed [30:0] acc_b;
    rgb_t               rgb_reg;
    rgb_t               rgb_next;

    assign p_rv_next = COEF_RV * vc_in;
    assign p_gu_next = COEF_GU * uc_in;
    assign p_gv_next = COEF_GV * vc_in;
    assign p_bu_next = COEF_BU * uc_in;

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            y_reg    <= y_in;
            p_rv_reg <= p_rv_next;
            p_gu_reg <= p_gu_next;
            p_gv_reg <= p_gv_next;
            p_bu_reg <= p_bu_next;
        end
    end

    always_comb
    begin
        yy             = $signed({5'b00000, y_reg, 16'h0000});
        acc_r          = yy + $signed({{2{p_rv_reg[28]}}, p_rv_reg});
        acc_g          = yy - $signed({{2{p_gu_reg[28]}}, p_gu_reg})
                            - $signed({{2{p_gv_reg[28]}}, p_gv_reg});
        acc_b          = yy + $signed({{2{p_bu_reg[28]}}, p_bu_reg});
        rgb_next.red   = conv_channel(acc_r);
        rgb_next.green = conv_channel(acc_g);
        rgb_next.blue  = conv_channel(acc_b);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
            rgb_reg <= rgb_next;
    end

    assign rgb = rgb_reg;

endmodule

`default_nettype wire

>>> src/yuv_diff_pixel_renderer.sv
// ----------------------------------------------------------------------------
// yuv_diff_pixel_renderer
// Per-pixel renderer for a two-frame yuv difference viewer.
// ----------------------------------------------------------------------------
// One pixel transaction carries the y/u/v samples of frames a and b, a
// difference magnitude, a mask bit and the column; one rgb transaction comes
// back per pixel. The block takes one pixel per clock while in_ready is high.
// It has a select stage (frame choice, depth shift, heat table read), a
// coefficient product stage, a sum and clamp stage and the output register.
// Each stage holds its item while the stage after it is full and stalled, so
// the input keeps taking pixels as long as there is an empty stage anywhere
// in the pipe. The heatmap colors sit in two 256-entry constant tables (8-bit
// and 10-bit depth) built at elaboration; there is no fill or clearing pass.
// ten_bit and frame_width are written through cfg_we/cfg_index/cfg_data; the
// user must do so while no pixel is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv_diff_pixel_renderer
    import ydr_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [12:0] cfg_data,

    // pixel input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  mode,
    input  wire logic [9:0]  y_a,
    input  wire logic [9:0]  u_a,
    input  wire logic [9:0]  v_a,
    input  wire logic [9:0]  y_b,
    input  wire logic [9:0]  u_b,
    input  wire logic [9:0]  v_b,
    input  wire logic [9:0]  diff_value,
    input  wire logic        mask_set,
    input  wire logic [11:0] column,
    input  wire logic        b_present,

    // rgb output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic             missing_b
);

    // compare width: enough for both the register and the clamp value
    localparam int unsigned W_BITS   = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CMP_BITS = (W_BITS > 13) ? W_BITS : 13;

    // configuration registers
    logic        ten_bit_reg;
    logic [12:0] frame_width_reg;

    // stage valids and advance strobes
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    ydr_adv_t adv;

    // stage 1 payload
    logic [1:0]         s1_kind_reg;
    logic [9:0]         s1_y_reg;
    logic signed [10:0] s1_uc_reg;
    logic signed [10:0] s1_vc_reg;

    // stage 2 and 3 side payload
    logic [1:0] s2_kind_reg;
    logic [1:0] s3_kind_reg;
    rgb_t       s2_heat_reg;
    rgb_t       s3_heat_reg;

    // output registers
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic       missing_b_reg;

    // stage 1 select logic
    logic [CMP_BITS-1:0] width_lim;
    logic [CMP_BITS-1:0] split_col;
    logic                right_side;
    logic                use_b;
    logic [1:0]          kind_next;
    logic [9:0]          y_src;
    logic [9:0]          u_src;
    logic [9:0]          v_src;
    logic [9:0]          y_next;
    logic [9:0]          u_sh;
    logic [9:0]          v_sh;
    logic signed [10:0]  uc_next;
    logic signed [10:0]  vc_next;

    rgb_t heat_rgb;
    rgb_t csc_rgb;

    // last stage
    logic [23:0] blend_r;
    logic [23:0] blend_g;
    logic [23:0] blend_b;
    logic [7:0]  red_next;
    logic [7:0]  green_next;
    logic [7:0]  blue_next;
    logic        missing_b_next;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ten_bit_reg     <= 1'b0;
            frame_width_reg <= FRAME_WIDTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEN_BIT:     ten_bit_reg     <= cfg_data[0];
                CFG_FRAME_WIDTH: frame_width_reg <= cfg_data;
                default:         ten_bit_reg     <= ten_bit_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline flow: a stage moves when it is empty or the next one moves
    // ------------------------------------------------------------------
    assign en4      = !out_valid_reg || out_ready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;
    assign adv.s2   = en2;
    assign adv.s3   = en3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= in_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
            if (en4)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: frame choice, depth shift, chroma offset
    // ------------------------------------------------------------------
    always_comb
    begin
        // split column is half the clamped row width
        width_lim  = (CMP_BITS'(frame_width_reg) > CMP_BITS'(MAX_WIDTH))
                   ? CMP_BITS'(MAX_WIDTH) : CMP_BITS'(frame_width_reg);
        split_col  = width_lim >> 1;
        right_side = CMP_BITS'(column) >= split_col;

        use_b     = 1'b0;
        kind_next = KIND_CSC;
        unique case (mode)
            MODE_A:
                use_b = 1'b0;
            MODE_B:
            begin
                use_b     = 1'b1;
                kind_next = b_present ? KIND_CSC : KIND_MISSING;
            end
            MODE_HEAT:
                kind_next = KIND_HEAT;
            MODE_MASK:
                kind_next = mask_set ? KIND_BLEND : KIND_CSC;
            MODE_COMPARE:
                // frame b only when present and right of the split
                use_b = b_present && right_side;
            default:
                // unused codes render frame a
                use_b = 1'b0;
        endcase

        y_src = use_b ? y_b : y_a;
        u_src = use_b ? u_b : u_a;
        v_src = use_b ? v_b : v_a;

        // 10-bit samples drop their two low bits
        y_next = ten_bit_reg ? {2'b00, y_src[9:2]} : y_src;
        u_sh   = ten_bit_reg ? {2'b00, u_src[9:2]} : u_src;
        v_sh   = ten_bit_reg ? {2'b00, v_src[9:2]} : v_src;

        uc_next = $signed({1'b0, u_sh}) - 11'sd128;
        vc_next = $signed({1'b0, v_sh}) - 11'sd128;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_kind_reg <= kind_next;
            s1_y_reg    <= y_next;
            s1_uc_reg   <= uc_next;
            s1_vc_reg   <= vc_next;
        end
    end

    // heat color read lines up with stage 1
    ydr_heat_rom u_heat_rom (
        .clk        (clk),
        .en         (en1),
        .ten_bit    (ten_bit_reg),
        .diff_value (diff_value),
        .rgb        (heat_rgb)
    );

    // ------------------------------------------------------------------
    // stages 2 and 3: color conversion, with the side data riding along
    // ------------------------------------------------------------------
    ydr_csc u_csc (
        .clk    (clk),
        .adv    (adv),
        .y_in   (s1_y_reg),
        .uc_in  (s1_uc_reg),
        .vc_in  (s1_vc_reg),
        .rgb    (csc_rgb)
    );

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_heat_reg <= heat_rgb;
        end
        if (en3)
        begin
            s3_kind_reg <= s2_kind_reg;
            s3_heat_reg <= s2_heat_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: mask blend toward red and final pixel select
    // ------------------------------------------------------------------
    always_comb
    begin
        blend_r = BLEND_RED_BIAS + BLEND_GAIN * {16'h0000, csc_rgb.red};
        blend_g = BLEND_BIAS + BLEND_GAIN * {16'h0000, csc_rgb.green};
        blend_b = BLEND_BIAS + BLEND_GAIN * {16'h0000, csc_rgb.blue};

        missing_b_next = 1'b0;
        unique case (s3_kind_reg)
            KIND_CSC:
            begin
                red_next   = csc_rgb.red;
                green_next = csc_rgb.green;
                blue_next  = csc_rgb.blue;
            end
            KIND_MISSING:
            begin
                red_next       = 8'd0;
                green_next     = 8'd0;
                blue_next      = 8'd0;
                missing_b_next = 1'b1;
            end
            KIND_HEAT:
            begin
                red_next   = s3_heat_reg.red;
                green_next = s3_heat_reg.green;
                blue_next  = s3_heat_reg.blue;
            end
            default:
            begin
                red_next   = blend_r[23:16];
                green_next = blend_g[23:16];
                blue_next  = blend_b[23:16];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            missing_b_reg <= missing_b_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign missing_b = missing_b_reg;

endmodule

`default_nettype wire

>>> src/ydr_checker.sv
// ----------------------------------------------------------------------------
// ydr_checker
// Port-level checks on the renderer, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ydr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] red,
    input wire logic [7:0] green,
    input wire logic [7:0] blue,
    input wire logic       missing_b
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
            && $stable(blue) && $stable(missing_b))
        else $error("output transaction changed while stalled");

    // input only backs up when the pipe is full and the output is stalled
    a_ready_bp: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with room in the pipe");

    // missing frame b pixel is black
    a_missing_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && missing_b |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
        else $error("missing frame b pixel is not black");

    // the pipe comes out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && in_ready)
        else $error("pipe not empty after reset");

endmodule

bind yuv_diff_pixel_renderer ydr_checker u_ydr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .missing_b (missing_b)
);

`default_nettype wire
